@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define MNC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true, disabled while reset is asserted.
`define MNC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/mnc_pkg.sv @@
`timescale 1ns / 1ps

package mnc_pkg;

    localparam int MAX_SIZE_DEFAULT = 32;
    localparam int BOARD_SIZE_RESET = 32;

    localparam int CFG_W     = 6;
    localparam int COUNT_W   = 4;
    localparam int POS_W     = 5;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int ITEM_W    = COUNT_W + 2 * POS_W;
    localparam int PAD_W     = M_TDATA_W - ITEM_W;

    typedef struct packed {
        logic               done;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic [COUNT_W-1:0] count;
    } out_item_t;

endpackage

@@ src/moore_neighbour_counter_core.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Signals                         Payload
// s_*       in   s_tvalid s_tready s_tdata[7:0]  [0] cell_alive, [7:1] zero
// m_*       out  m_tvalid m_tready m_tdata[15:0] [3:0] count, [8:4] row,
//                m_tlast                         [13:9] col, [15:14] zero; tlast=board_done
// cfg_*     in   cfg_wr_en cfg_wr_data[5:0]      board_size
//
// One cell transaction per cycle while the board streams in and the skid entry
// is empty; the count of a cell passes through the shift line, the window
// stage and the output register. After the board's last cell the input
// stalls while zeros are shifted through the line to flush the last counts.
// Reset (rst_n, async low) clears all control state and sets board size 32 (MAX_SIZE if smaller).
// A stalled output fills the skid entry, which drops s_tready and freezes
// the shift line until the entry drains.
module moore_neighbour_counter_core #(
    parameter int MAX_SIZE = mnc_pkg::MAX_SIZE_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mnc_pkg::S_TDATA_W-1:0] s_tdata,   // [0] cell_alive
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mnc_pkg::M_TDATA_W-1:0] m_tdata,   // count, cell_row, cell_col
    output logic                          m_tlast,   // board_done
    input  logic                          cfg_wr_en,
    input  logic [mnc_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int CW       = $clog2(MAX_SIZE + 2);
    localparam int LINE_LEN = 2 * MAX_SIZE + 3;
    localparam int RESET_SIZE =
        (mnc_pkg::BOARD_SIZE_RESET > MAX_SIZE) ? MAX_SIZE : mnc_pkg::BOARD_SIZE_RESET;

    // Effective side length, clamped at write time
    logic [CW-1:0] size_reg;
    logic [CW-1:0] size_next;

    // Position of the next step (real or flush) and of the next count owed
    logic [CW-1:0] in_row_reg;
    logic [CW-1:0] in_row_next;
    logic [CW-1:0] in_col_reg;
    logic [CW-1:0] in_col_next;
    logic [CW-1:0] out_row_reg;
    logic [CW-1:0] out_row_next;
    logic [CW-1:0] out_col_reg;
    logic [CW-1:0] out_col_next;
    logic          flush_reg;
    logic          flush_next;

    // Window stage: center position of the count being formed
    logic          a_valid_reg;
    logic          a_valid_next;
    logic [CW-1:0] a_row_reg;
    logic [CW-1:0] a_row_next;
    logic [CW-1:0] a_col_reg;
    logic [CW-1:0] a_col_next;
    logic          a_done_reg;
    logic          a_done_next;

    logic                        enable;
    logic                        step;
    logic                        emit;
    logic                        last_real;
    logic                        out_done;
    logic                        shift_bit;
    logic [CW-1:0]               last_pos;
    logic [LINE_LEN-1:0]         taps;
    logic [mnc_pkg::COUNT_W-1:0] count;
    logic                        skid_full;
    mnc_pkg::out_item_t          push_item;
    mnc_pkg::out_item_t          out_item;

    assign enable    = !skid_full;
    assign s_tready  = enable && !flush_reg;
    assign step      = enable && (flush_reg || s_tvalid);
    assign shift_bit = flush_reg ? 1'b0 : s_tdata[0];
    assign last_pos  = size_reg - CW'(1);
    assign last_real = (in_row_reg == last_pos) && (in_col_reg == last_pos);
    assign out_done  = (out_row_reg == last_pos) && (out_col_reg == last_pos);

    // counts start once n+1 cells are in the line
    assign emit = step && ((in_row_reg > CW'(1)) ||
                           ((in_row_reg == CW'(1)) && (in_col_reg != '0)));

    always_comb
    begin
        size_next    = size_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        flush_next   = flush_reg;
        a_valid_next = a_valid_reg;
        a_row_next   = a_row_reg;
        a_col_next   = a_col_reg;
        a_done_next  = a_done_reg;

        if (step)
        begin
            if (in_col_reg == last_pos)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + CW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (!flush_reg && last_real)
            begin
                flush_next = 1'b1;
            end
        end

        if (enable)
        begin
            a_valid_next = emit;
        end

        if (emit)
        begin
            a_row_next  = out_row_reg;
            a_col_next  = out_col_reg;
            a_done_next = out_done;
            if (out_done)
            begin
                // board complete: line restarts on the next transaction
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
                flush_next   = 1'b0;
            end
            else if (out_col_reg == last_pos)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + CW'(1);
            end
            else
            begin
                out_col_next = out_col_reg + CW'(1);
            end
        end

        if (cfg_wr_en)
        begin
            // zero acts as 1, anything above MAX_SIZE as MAX_SIZE
            if (cfg_wr_data == '0)
            begin
                size_next = CW'(1);
            end
            else if (cfg_wr_data > mnc_pkg::CFG_W'(MAX_SIZE))
            begin
                size_next = CW'(MAX_SIZE);
            end
            else
            begin
                size_next = CW'(cfg_wr_data);
            end
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            flush_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= CW'(RESET_SIZE);
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            flush_reg   <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg    <= size_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            flush_reg   <= flush_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_row_reg  <= a_row_next;
        a_col_reg  <= a_col_next;
        a_done_reg <= a_done_next;
    end

    // Shift line: tap 0 is the newest cell, two rows plus three cells deep
    genvar gi;
    generate
        for (gi = 0; gi < LINE_LEN; gi++)
        begin : g_line
            if (gi == 0)
            begin : g_head
                mnc_cell u_cell (
                    .clk (clk),
                    .en  (step),
                    .d   (shift_bit),
                    .q   (taps[gi])
                );
            end
            else
            begin : g_body
                mnc_cell u_cell (
                    .clk (clk),
                    .en  (step),
                    .d   (taps[gi-1]),
                    .q   (taps[gi])
                );
            end
        end
    endgenerate

    mnc_window #(
        .MAX_SIZE (MAX_SIZE),
        .CW       (CW),
        .LINE_LEN (LINE_LEN)
    ) u_window (
        .taps  (taps),
        .size  (size_reg),
        .row   (a_row_reg),
        .col   (a_col_reg),
        .count (count)
    );

    always_comb
    begin
        push_item.count = count;
        push_item.row   = mnc_pkg::POS_W'(a_row_reg);
        push_item.col   = mnc_pkg::POS_W'(a_col_reg);
        push_item.done  = a_done_reg;
    end

    mnc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (a_valid_reg && enable),
        .push_item (push_item),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .item      (out_item),
        .full      (skid_full)
    );

    assign m_tdata = {{mnc_pkg::PAD_W{1'b0}}, out_item.col, out_item.row, out_item.count};
    assign m_tlast = out_item.done;

    // the flush runs the input row up to two past the board's last row
    `MNC_ASSERT(a_col_in_range, clk, rst_n, in_col_reg < size_reg, "input column out of range")
    `MNC_ASSERT(a_row_in_range, clk, rst_n, in_row_reg <= size_reg + CW'(1), "input row out of range")
    `MNC_ASSERT(a_done_ends_flush, clk, rst_n, a_valid_reg && a_done_reg |-> !flush_reg, "flush after last count")
    `MNC_ASSERT(a_frozen_line, clk, rst_n, skid_full |=> $stable(taps), "line moved while stalled")

endmodule

@@ src/mnc_cell.sv @@
`timescale 1ns / 1ps

// One stage of the cell shift line.
module mnc_cell (
    input  logic clk,
    input  logic en,
    input  logic d,
    output logic q
);

    logic bit_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bit_reg <= d;
        end
    end

    assign q = bit_reg;

endmodule

@@ src/mnc_window.sv @@
`timescale 1ns / 1ps

// Picks the eight neighbor taps out of the shift line, masks the ones that
// fall off the board and adds them up.
module mnc_window #(
    parameter int MAX_SIZE = mnc_pkg::MAX_SIZE_DEFAULT,
    parameter int CW       = $clog2(MAX_SIZE + 2),
    parameter int LINE_LEN = 2 * MAX_SIZE + 3
) (
    input  logic [LINE_LEN-1:0]         taps,
    input  logic [CW-1:0]               size,
    input  logic [CW-1:0]               row,
    input  logic [CW-1:0]               col,
    output logic [mnc_pkg::COUNT_W-1:0] count
);

    localparam int IW = $clog2(LINE_LEN);

    logic [IW-1:0] idx_n;
    logic [IW-1:0] idx_2n;
    logic [CW-1:0] last_pos;
    logic          top_ok;
    logic          bot_ok;
    logic          left_ok;
    logic          right_ok;
    logic [7:0]    nb;

    assign idx_n    = IW'(size);
    assign idx_2n   = idx_n << 1;
    assign last_pos = size - CW'(1);

    assign top_ok   = (row != '0);
    assign bot_ok   = (row != last_pos);
    assign left_ok  = (col != '0);
    assign right_ok = (col != last_pos);

    // tap j holds the cell that entered j steps ago; the center sits at n+1
    assign nb[0] = taps[0] & bot_ok & right_ok;
    assign nb[1] = taps[1] & bot_ok;
    assign nb[2] = taps[2] & bot_ok & left_ok;
    assign nb[3] = taps[idx_n] & right_ok;
    assign nb[4] = taps[idx_n + IW'(2)] & left_ok;
    assign nb[5] = taps[idx_2n] & top_ok & right_ok;
    assign nb[6] = taps[idx_2n + IW'(1)] & top_ok;
    assign nb[7] = taps[idx_2n + IW'(2)] & top_ok & left_ok;

    always_comb
    begin
        count = '0;
        for (int i = 0; i < 8; i++)
        begin
            count = count + mnc_pkg::COUNT_W'(nb[i]);
        end
    end

endmodule

@@ src/mnc_skid.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Output register plus one skid entry.
module mnc_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mnc_pkg::out_item_t push_item,
    input  logic               m_tready,
    output logic               m_tvalid,
    output mnc_pkg::out_item_t item,
    output logic               full
);

    logic               main_valid_reg;
    logic               main_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    mnc_pkg::out_item_t main_reg;
    mnc_pkg::out_item_t main_next;
    mnc_pkg::out_item_t skid_reg;
    mnc_pkg::out_item_t skid_next;
    logic               pop;

    assign pop = main_valid_reg & m_tready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_item;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = main_valid_reg;
    assign item     = main_reg;
    assign full     = skid_valid_reg;

    `MNC_ASSERT(a_skid_needs_main, clk, rst_n, skid_valid_reg |-> main_valid_reg, "skid without main")
    `MNC_ASSERT(a_main_holds, clk, rst_n, main_valid_reg && !m_tready |=> main_valid_reg, "result lost")
    `MNC_NEVER(a_no_push_full, clk, rst_n, push && skid_valid_reg, "push into full buffer")

endmodule
